FILE: sv/ciht_pkg.sv
`timescale 1ns / 1ps
// ciht_pkg: shared field widths, codes and types of the collision-invalidating hash table
// used by the channel interfaces, the hash unit and the top level; depends on nothing

package ciht_pkg;

  localparam int DIGIT_W   = 4;
  localparam int KEY_W     = 64;
  localparam int AREA_W    = 32;
  localparam int ID_W      = 16;
  localparam int IDX_W     = 12;
  localparam int STATUS_W  = 3;
  localparam int RADIX_W   = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = RADIX_W;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_AREA = 1'b1;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    TAG_FREE    = 2'd0,
    TAG_VALID   = 2'd1,
    TAG_INVALID = 2'd2
  } tag_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED    = 3'd0,
    ST_COLLIDED  = 3'd1,
    ST_ALREADY   = 3'd2,
    ST_HIT       = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_INVALID   = 3'd5
  } status_t;

  // command from the controller to the digit-serial hash unit
  typedef struct packed {
    logic               start;
    logic               use_area;
    logic [RADIX_W-1:0] radix;
  } hash_req_t;

endpackage

FILE: sv/ciht_if.sv
`timescale 1ns / 1ps
// ciht_in_if / ciht_out_if: valid-ready channels for query items and result items
// depends on ciht_pkg

interface ciht_in_if;
  import ciht_pkg::*;
  logic                valid;
  logic                ready;
  logic                mode;
  logic [KEY_W-1:0]    key_digits;
  logic [AREA_W-1:0]   area_digits;
  logic [ID_W-1:0]     doc_id;
  logic [ID_W-1:0]     point_id;

  modport source(output valid, mode, key_digits, area_digits, doc_id, point_id,
                 input ready);
  modport sink(input valid, mode, key_digits, area_digits, doc_id, point_id,
               output ready);
endinterface

interface ciht_out_if;
  import ciht_pkg::*;
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    hash_index;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     found_doc;
  logic [ID_W-1:0]     found_point;

  modport source(output valid, hash_index, status, found_doc, found_point,
                 input ready);
  modport sink(input valid, hash_index, status, found_doc, found_point,
               output ready);
endinterface

FILE: sv/ciht_ram.sv
`timescale 1ns / 1ps
// ciht_ram: generic single-write, single-read memory with registered read data
// standalone, no package needed

module ciht_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/ciht_hash.sv
`timescale 1ns / 1ps
// ciht_hash: digit-serial polynomial hash, one 4-bit digit per cycle from a shift register
// depends on ciht_pkg (digit width, request struct)

module ciht_hash #(
  parameter int NUM_DIGITS      = 16,
  parameter int NUM_AREA_DIGITS = 8,
  parameter int HASH_SIZE       = 4096
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ciht_pkg::hash_req_t          req,
  input  logic [ciht_pkg::KEY_W-1:0]   key_digits,
  input  logic [ciht_pkg::AREA_W-1:0]  area_digits,
  output logic                         done,
  output logic [$clog2(HASH_SIZE)-1:0] index
);
  import ciht_pkg::*;

  localparam int HW = $clog2(HASH_SIZE);
  localparam int PW = HW + 6;
  localparam int NT = NUM_AREA_DIGITS + NUM_DIGITS;
  localparam int SW = NT * DIGIT_W;
  localparam int KW = NUM_DIGITS * DIGIT_W;
  localparam int AW = NUM_AREA_DIGITS * DIGIT_W;
  localparam int CW = $clog2(NT + 1);
  localparam int ACW = $clog2(NUM_AREA_DIGITS + 1);

  logic [SW-1:0]      sreg;
  logic [HW-1:0]      h;
  logic [CW-1:0]      left;
  logic [ACW-1:0]     area_left;
  logic               busy;
  logic [RADIX_W-1:0] radix;
  logic [RADIX_W-1:0] mult;
  logic [HW-1:0]      h_next;

  assign mult = (area_left != '0) ? RADIX_W'(NUM_AREA_DIGITS) : radix;

  // h * mult + digit stays below 32 * HASH_SIZE, so five conditional subtracts reduce it
  always_comb begin
    logic [PW-1:0] p;
    p = PW'(h) * PW'(mult) + PW'(sreg[DIGIT_W-1:0]);
    for (int k = 4; k >= 0; k--) begin
      if (p >= (PW'(HASH_SIZE) << k)) begin
        p = p - (PW'(HASH_SIZE) << k);
      end
    end
    h_next = p[HW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && left == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      h     <= '0;
      radix <= req.radix;
      if (req.use_area) begin
        sreg      <= {key_digits[KW-1:0], area_digits[AW-1:0]};
        left      <= CW'(NT);
        area_left <= ACW'(NUM_AREA_DIGITS);
      end else begin
        sreg      <= {{AW{1'b0}}, key_digits[KW-1:0]};
        left      <= CW'(NUM_DIGITS);
        area_left <= '0;
      end
    end else if (busy) begin
      h    <= h_next;
      sreg <= sreg >> DIGIT_W;
      left <= left - CW'(1);
      if (area_left != '0) begin
        area_left <= area_left - ACW'(1);
      end
    end
  end

  assign index = h;

endmodule

FILE: sv/collision_invalidating_hash_table_core.sv
`timescale 1ns / 1ps
// collision_invalidating_hash_table_core: controller, slot memory and result register
// depends on ciht_pkg, ciht_if, ciht_ram and ciht_hash

// Direct-mapped table of HASH_SIZE slots indexed by a polynomial hash of the key digits
// (area digits first when use_area is set). An insert fills a free slot, turns a valid slot
// invalid and leaves an invalid slot alone; a lookup reports the slot state and, on a hit,
// the stored doc and point ids. One item is in flight at a time; the hash unit consumes one
// digit per cycle, area digits included when use_area is set, followed by one slot read and
// one read-modify-write, which waits while the result register is full and not being taken.
// A waiting result does not block acceptance of the next item.
// After reset the slot memory is swept to free, one slot per cycle, over all HASH_SIZE slots;
// no item is accepted during the sweep, configuration writes are.

module collision_invalidating_hash_table_core #(
  parameter int NUM_DIGITS      = 16,
  parameter int NUM_AREA_DIGITS = 8,
  parameter int HASH_SIZE       = 4096,
  parameter int DOC_BITS        = 16,
  parameter int POINT_BITS      = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [ciht_pkg::CFG_IDX_W-1:0]     wr_index,
  input  logic [ciht_pkg::CFG_DATA_W-1:0]    wr_data,
  ciht_in_if.sink                            query,
  ciht_out_if.source                         result
);
  import ciht_pkg::*;

  localparam int HW = $clog2(HASH_SIZE);
  localparam int EW = DOC_BITS + POINT_BITS;
  localparam int RW = EW + 2;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_READ  = 5'b01000,
    S_UPD   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [RADIX_W-1:0]  radix;
  logic                use_area;
  logic [HW-1:0]       clr_addr;
  logic [HW-1:0]       slot_idx;
  logic                mode;
  logic [DOC_BITS-1:0]   doc_cut;
  logic [POINT_BITS-1:0] point_cut;

  logic                res_valid;
  logic [IDX_W-1:0]    res_index;
  logic [STATUS_W-1:0] res_status;
  logic [ID_W-1:0]     res_doc;
  logic [ID_W-1:0]     res_point;

  hash_req_t           hash_req;
  logic                hash_done;
  logic [HW-1:0]       hash_index;

  logic                ram_we;
  logic [HW-1:0]       ram_waddr;
  logic [RW-1:0]       ram_wdata;
  logic                ram_re;
  logic [RW-1:0]       ram_rdata;

  logic [1:0]            rd_tag;
  logic [DOC_BITS-1:0]   rd_doc;
  logic [POINT_BITS-1:0] rd_point;

  logic                  accept;
  logic                  can_load;
  logic                  upd_we;
  logic [RW-1:0]         upd_wdata;
  logic [STATUS_W-1:0]   upd_status;
  logic [ID_W-1:0]       upd_doc;
  logic [ID_W-1:0]       upd_point;
  logic [IDX_W-1:0]      idx_out;

  logic [ID_W+DOC_BITS-1:0]    doc_in_wide;
  logic [ID_W+POINT_BITS-1:0]  point_in_wide;
  logic [ID_W+DOC_BITS-1:0]    doc_out_wide;
  logic [ID_W+POINT_BITS-1:0]  point_out_wide;
  logic [IDX_W+HW-1:0]         idx_wide;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radix    <= RADIX_RESET;
      use_area <= 1'b0;
    end else if (wr_en) begin
      if (wr_index == CFG_RADIX) begin
        radix <= wr_data;
      end else if (wr_index == CFG_USE_AREA) begin
        use_area <= wr_data[0];
      end
    end
  end

  assign query.ready = (state == S_IDLE);
  assign accept      = query.valid && query.ready;
  assign can_load    = !res_valid || result.ready;

  assign hash_req.start    = accept;
  assign hash_req.use_area = use_area;
  assign hash_req.radix    = radix;

  ciht_hash #(
    .NUM_DIGITS      (NUM_DIGITS),
    .NUM_AREA_DIGITS (NUM_AREA_DIGITS),
    .HASH_SIZE       (HASH_SIZE)
  ) u_hash (
    .clk         (clk),
    .rst         (rst),
    .req         (hash_req),
    .key_digits  (query.key_digits),
    .area_digits (query.area_digits),
    .done        (hash_done),
    .index       (hash_index)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == HW'(HASH_SIZE - 1)) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = S_HASH;
      S_HASH:  if (hash_done) state_next = S_READ;
      S_READ:  state_next = S_UPD;
      S_UPD:   if (can_load) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + HW'(1);
      end
    end
  end

  // ids cut or zero-extended to the stored widths
  assign doc_in_wide   = {{DOC_BITS{1'b0}}, query.doc_id};
  assign point_in_wide = {{POINT_BITS{1'b0}}, query.point_id};

  always_ff @(posedge clk) begin
    if (accept) begin
      mode      <= query.mode;
      doc_cut   <= doc_in_wide[DOC_BITS-1:0];
      point_cut <= point_in_wide[POINT_BITS-1:0];
    end
    if (state == S_HASH && hash_done) begin
      slot_idx <= hash_index;
    end
  end

  // slot word: {tag, doc, point}
  assign rd_tag   = ram_rdata[RW-1:EW];
  assign rd_doc   = ram_rdata[EW-1:POINT_BITS];
  assign rd_point = ram_rdata[POINT_BITS-1:0];

  assign doc_out_wide   = {{ID_W{1'b0}}, rd_doc};
  assign point_out_wide = {{ID_W{1'b0}}, rd_point};

  always_comb begin
    upd_we     = 1'b0;
    upd_wdata  = ram_rdata;
    upd_doc    = '0;
    upd_point  = '0;
    if (mode == MODE_INSERT) begin
      if (rd_tag == TAG_FREE) begin
        upd_we     = 1'b1;
        upd_wdata  = {TAG_VALID, doc_cut, point_cut};
        upd_status = ST_STORED;
      end else if (rd_tag == TAG_VALID) begin
        upd_we     = 1'b1;
        upd_wdata  = {TAG_INVALID, rd_doc, rd_point};
        upd_status = ST_COLLIDED;
      end else begin
        upd_status = ST_ALREADY;
      end
    end else begin
      if (rd_tag == TAG_VALID) begin
        upd_status = ST_HIT;
        upd_doc    = doc_out_wide[ID_W-1:0];
        upd_point  = point_out_wide[ID_W-1:0];
      end else if (rd_tag == TAG_FREE) begin
        upd_status = ST_EMPTY;
      end else begin
        upd_status = ST_INVALID;
      end
    end
  end

  assign ram_re    = (state == S_READ);
  assign ram_we    = (state == S_CLEAR) || (state == S_UPD && can_load && upd_we);
  assign ram_waddr = (state == S_CLEAR) ? clr_addr : slot_idx;
  assign ram_wdata = (state == S_CLEAR) ? {TAG_FREE, {EW{1'b0}}} : upd_wdata;

  ciht_ram #(
    .WIDTH (RW),
    .DEPTH (HASH_SIZE)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot_idx),
    .rdata (ram_rdata)
  );

  assign idx_wide = {{IDX_W{1'b0}}, slot_idx};
  assign idx_out  = idx_wide[IDX_W-1:0];

  // result register, parts the slot update from the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == S_UPD && can_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_UPD && can_load) begin
      res_index  <= idx_out;
      res_status <= upd_status;
      res_doc    <= upd_doc;
      res_point  <= upd_point;
    end
  end

  assign result.valid       = res_valid;
  assign result.hash_index  = res_index;
  assign result.status      = res_status;
  assign result.found_doc   = res_doc;
  assign result.found_point = res_point;

  a_result_after_update: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == S_UPD))
    else $error("result raised without a slot update");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_UPD))
    else $error("slot memory written outside sweep or update");

  a_hash_done_state: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> state == S_HASH)
    else $error("hash finished while controller not waiting");

  a_ids_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status != ST_HIT) |-> (res_doc == '0 && res_point == '0))
    else $error("ids reported without a lookup hit");

endmodule
